### hw/rtl/dre_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the DNS reply address extractor.
// Depends on nothing; every other file of the block imports it.
package dre_pkg;

    localparam int MaxMessageBytes = 2048;
    localparam int OffsetW         = $clog2(MaxMessageBytes + 1);
    localparam int HeaderBytes     = 12;
    localparam int HdrIdxW         = 4;
    localparam int QendW           = 10;
    localparam int IdW             = 16;
    localparam int CountW          = 16;
    localparam int SkipW           = CountW + 1;
    localparam int AddrW           = 32;
    localparam int StatusW         = 3;
    localparam int CfgIdxW         = 1;
    localparam int CfgDataW        = 16;
    localparam int QueueDepth      = 2;
    localparam int QueuePtrW       = $clog2(QueueDepth);
    localparam int QueueCntW       = $clog2(QueueDepth + 1);

    typedef logic [StatusW-1:0] status_t;

    localparam status_t ST_FOUND         = 3'd0;
    localparam status_t ST_NO_ANSWERS    = 3'd1;
    localparam status_t ST_NO_ADDITIONAL = 3'd2;
    localparam status_t ST_BAD_LENGTH    = 3'd3;
    localparam status_t ST_ID_MISMATCH   = 3'd4;
    localparam status_t ST_TRUNCATED     = 3'd5;

    localparam logic [CfgIdxW-1:0] CFG_QUERY_ID     = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_QUESTION_END = 1'd1;

    localparam logic [IdW-1:0]   QueryIdReset   = 16'd255;
    localparam logic [QendW-1:0] QendMin        = 10'd12;
    localparam logic [7:0]       LabelLimit     = 8'd64;
    localparam logic [1:0]       PointerMark    = 2'b11;
    localparam logic [15:0]      FixedBytes     = 16'd8;
    localparam logic [15:0]      AddressBytes   = 16'd4;

    localparam logic [HdrIdxW-1:0] HDR_ID_HI   = 4'd0;
    localparam logic [HdrIdxW-1:0] HDR_ID_LO   = 4'd1;
    localparam logic [HdrIdxW-1:0] HDR_AN_HI   = 4'd6;
    localparam logic [HdrIdxW-1:0] HDR_AN_LO   = 4'd7;
    localparam logic [HdrIdxW-1:0] HDR_NS_HI   = 4'd8;
    localparam logic [HdrIdxW-1:0] HDR_NS_LO   = 4'd9;
    localparam logic [HdrIdxW-1:0] HDR_AR_HI   = 4'd10;
    localparam logic [HdrIdxW-1:0] HDR_AR_LO   = 4'd11;

    // One message byte, tagged by the front end with its position.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               last_byte;
        logic               in_range;
        logic               is_header;
        logic [HdrIdxW-1:0] hdr_idx;
        logic               past_question;
    } beat_t;

    typedef enum logic [10:0] {
        PH_HEADER   = 11'b000_0000_0001,
        PH_QUESTION = 11'b000_0000_0010,
        PH_NAME     = 11'b000_0000_0100,
        PH_LABEL    = 11'b000_0000_1000,
        PH_POINTER  = 11'b000_0001_0000,
        PH_FIXED    = 11'b000_0010_0000,
        PH_LEN_HI   = 11'b000_0100_0000,
        PH_LEN_LO   = 11'b000_1000_0000,
        PH_DATA     = 11'b001_0000_0000,
        PH_ADDR     = 11'b010_0000_0000,
        PH_DONE     = 11'b100_0000_0000
    } phase_t;

endpackage

### hw/rtl/dre_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the DNS reply address extractor.
// Depends on dre_pkg for payload widths.

interface dre_byte_if;
    import dre_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dre_result_if;
    import dre_pkg::*;
    logic              valid;
    logic              ready;
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] answer_total;
    logic [CountW-1:0] additional_total;
    modport source (output valid, output status, output address, output answer_total,
                    output additional_total, input ready);
    modport sink   (input valid, input status, input address, input answer_total,
                    input additional_total, output ready);
endinterface

interface dre_cfg_if;
    import dre_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/dre_front.sv
`timescale 1ns / 1ps
// Front end: accepts message bytes, tracks the byte offset and tags each beat.
// Depends on dre_pkg and dre_byte_if.
module dre_front (
    input  logic                     clk,
    input  logic                     rst_n,
    dre_byte_if.sink                 msg,
    input  logic [dre_pkg::QendW-1:0] question_end,
    input  logic                     queue_full,
    output logic                     push,
    output dre_pkg::beat_t           beat
);
    import dre_pkg::*;

    localparam int CmpW = (OffsetW > QendW) ? OffsetW : QendW;

    logic [OffsetW-1:0] offset_reg;
    logic [OffsetW-1:0] offset_next;
    logic [QendW-1:0]   qend_eff;
    logic               in_range;

    assign msg.ready = !queue_full;
    assign push      = msg.valid && !queue_full;

    // Offsets below the header length behave as the end of the header.
    assign qend_eff = (question_end < QendMin) ? QendMin : question_end;
    assign in_range = offset_reg < OffsetW'(MaxMessageBytes);

    always_comb
    begin
        beat.data_byte     = msg.data_byte;
        beat.last_byte     = msg.last_byte;
        beat.in_range      = in_range;
        beat.is_header     = offset_reg < OffsetW'(HeaderBytes);
        beat.hdr_idx       = offset_reg[HdrIdxW-1:0];
        beat.past_question = CmpW'(offset_reg) >= CmpW'(qend_eff);
    end

    always_comb
    begin
        offset_next = offset_reg;
        if (push)
        begin
            if (msg.last_byte)
                offset_next = '0;
            else if (in_range)
                offset_next = offset_reg + OffsetW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end

endmodule

### hw/rtl/dre_queue.sv
`timescale 1ns / 1ps
// Short beat queue between the front end and the parser.
// Depends on dre_pkg.
module dre_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dre_pkg::beat_t push_beat,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output dre_pkg::beat_t head
);
    import dre_pkg::*;

    beat_t                slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_next;
    logic [QueueCntW-1:0] count_reg;
    logic [QueueCntW-1:0] count_next;

    assign full      = count_reg == QueueCntW'(QueueDepth);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                        : wr_ptr_reg + QueuePtrW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                        : rd_ptr_reg + QueuePtrW'(1);
        if (push && !pop)
            count_next = count_reg + QueueCntW'(1);
        else if (pop && !push)
            count_next = count_reg - QueueCntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_beat;
    end

endmodule

### hw/rtl/dre_back.sv
`timescale 1ns / 1ps
// Back end: header capture, resource record walk and the result register.
// Depends on dre_pkg and dre_result_if.
module dre_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [dre_pkg::IdW-1:0] query_id,
    input  logic                   beat_valid,
    input  dre_pkg::beat_t         beat,
    output logic                   pop,
    dre_result_if.source           result
);
    import dre_pkg::*;

    phase_t              phase_reg,      phase_next;
    logic [IdW-1:0]      reply_id_reg,   reply_id_next;
    logic [CountW-1:0]   answer_reg,     answer_next;
    logic [CountW-1:0]   authority_reg,  authority_next;
    logic [CountW-1:0]   additional_reg, additional_next;
    logic [SkipW-1:0]    skipped_reg,    skipped_next;
    logic [15:0]         left_reg,       left_next;
    logic [7:0]          len_hi_reg,     len_hi_next;
    logic [AddrW-1:0]    addr_reg,       addr_next;
    status_t             outcome_reg,    outcome_next;

    logic                res_valid_reg,  res_valid_next;
    status_t             res_status_reg;
    logic [AddrW-1:0]    res_addr_reg;
    logic [CountW-1:0]   res_answer_reg;
    logic [CountW-1:0]   res_additional_reg;

    logic [7:0]          b;
    logic [15:0]         left_dec;
    logic [15:0]         data_len;
    logic                do_name;
    logic                slot_free;

    // A beat that ends the message needs the result register; others never wait.
    assign slot_free = !res_valid_reg || result.ready;
    assign pop       = beat_valid && (!beat.last_byte || slot_free);

    assign b        = beat.data_byte;
    assign left_dec = left_reg - 16'd1;
    assign data_len = {len_hi_reg, b};
    assign do_name  = (phase_reg == PH_NAME)
                   || ((phase_reg == PH_QUESTION) && beat.past_question);

    always_comb
    begin
        phase_next      = phase_reg;
        reply_id_next   = reply_id_reg;
        answer_next     = answer_reg;
        authority_next  = authority_reg;
        additional_next = additional_reg;
        skipped_next    = skipped_reg;
        left_next       = left_reg;
        len_hi_next     = len_hi_reg;
        addr_next       = addr_reg;
        outcome_next    = outcome_reg;

        if (pop && beat.in_range)
        begin
            if (do_name)
            begin
                if ((b != 8'd0) && (b < LabelLimit))
                begin
                    left_next  = {8'd0, b};
                    phase_next = PH_LABEL;
                end
                else if (b[7:6] == PointerMark)
                    phase_next = PH_POINTER;
                else
                begin
                    left_next  = FixedBytes;
                    phase_next = PH_FIXED;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (beat.is_header)
                        begin
                            unique case (beat.hdr_idx)
                                HDR_ID_HI: reply_id_next[15:8]  = b;
                                HDR_ID_LO: reply_id_next[7:0]   = b;
                                HDR_AN_HI: answer_next[15:8]    = b;
                                HDR_AN_LO: answer_next[7:0]     = b;
                                HDR_NS_HI: authority_next[15:8] = b;
                                HDR_NS_LO: authority_next[7:0]  = b;
                                HDR_AR_HI: additional_next[15:8] = b;
                                HDR_AR_LO: additional_next[7:0] = b;
                                default: ;
                            endcase
                            if (beat.hdr_idx == HDR_AR_LO)
                            begin
                                priority if (reply_id_next != query_id)
                                begin
                                    outcome_next = ST_ID_MISMATCH;
                                    phase_next   = PH_DONE;
                                end
                                else if (answer_next == '0)
                                begin
                                    outcome_next = ST_NO_ANSWERS;
                                    phase_next   = PH_DONE;
                                end
                                else if (additional_next == '0)
                                begin
                                    outcome_next = ST_NO_ADDITIONAL;
                                    phase_next   = PH_DONE;
                                end
                                else
                                    phase_next = PH_QUESTION;
                            end
                        end
                    end
                    PH_LABEL:
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                            phase_next = PH_NAME;
                    end
                    PH_POINTER:
                    begin
                        left_next  = FixedBytes;
                        phase_next = PH_FIXED;
                    end
                    PH_FIXED:
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                            phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        len_hi_next = b;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        // The record after all answers and authorities is the
                        // first additional record.
                        if (skipped_reg == (SkipW'(answer_reg) + SkipW'(authority_reg)))
                        begin
                            if (data_len != AddressBytes)
                            begin
                                outcome_next = ST_BAD_LENGTH;
                                phase_next   = PH_DONE;
                            end
                            else
                            begin
                                left_next  = AddressBytes;
                                addr_next  = '0;
                                phase_next = PH_ADDR;
                            end
                        end
                        else if (data_len == '0)
                        begin
                            skipped_next = skipped_reg + SkipW'(1);
                            phase_next   = PH_NAME;
                        end
                        else
                        begin
                            left_next  = data_len;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            skipped_next = skipped_reg + SkipW'(1);
                            phase_next   = PH_NAME;
                        end
                    end
                    PH_ADDR:
                    begin
                        addr_next = {addr_reg[AddrW-9:0], b};
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            outcome_next = ST_FOUND;
                            phase_next   = PH_DONE;
                        end
                    end
                    PH_QUESTION, PH_NAME, PH_DONE: ;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (pop && beat.last_byte)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            reply_id_reg   <= '0;
            answer_reg     <= '0;
            authority_reg  <= '0;
            additional_reg <= '0;
            skipped_reg    <= '0;
            left_reg       <= '0;
            len_hi_reg     <= '0;
            addr_reg       <= '0;
            outcome_reg    <= ST_TRUNCATED;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop && beat.last_byte)
            begin
                phase_reg      <= PH_HEADER;
                reply_id_reg   <= '0;
                answer_reg     <= '0;
                authority_reg  <= '0;
                additional_reg <= '0;
                skipped_reg    <= '0;
                left_reg       <= '0;
                len_hi_reg     <= '0;
                addr_reg       <= '0;
                outcome_reg    <= ST_TRUNCATED;
            end
            else
            begin
                phase_reg      <= phase_next;
                reply_id_reg   <= reply_id_next;
                answer_reg     <= answer_next;
                authority_reg  <= authority_next;
                additional_reg <= additional_next;
                skipped_reg    <= skipped_next;
                left_reg       <= left_next;
                len_hi_reg     <= len_hi_next;
                addr_reg       <= addr_next;
                outcome_reg    <= outcome_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && beat.last_byte)
        begin
            res_status_reg     <= outcome_next;
            res_addr_reg       <= (outcome_next == ST_FOUND) ? addr_next : '0;
            res_answer_reg     <= answer_next;
            res_additional_reg <= additional_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.status           = res_status_reg;
    assign result.address          = res_addr_reg;
    assign result.answer_total     = res_answer_reg;
    assign result.additional_total = res_additional_reg;

endmodule

### hw/rtl/dns_reply_address_extractor.sv
`timescale 1ns / 1ps
// DNS reply address extractor: top level with configuration registers.
// Depends on dre_pkg, the channel interfaces, dre_front, dre_queue and dre_back.
//
// Usage. The msg channel carries one byte of a DNS reply per beat; last_byte
// marks the final beat of a message. For each message exactly one beat leaves
// on the result channel: a status code, the IPv4 address of the first
// additional record when found, and the answer and additional counts from the
// header. The cfg channel writes the expected message id (index 0) and the
// offset of the first answer record (index 1); it is always ready and should
// be used only while no message is in flight.
// Throughput is one byte per cycle unless the queue is full. The front end
// tags each byte with its offset, a two-beat queue carries it to the record
// parser, and the result is registered when the parser takes the last byte.
// Reset clears the parser to the start of a message and loads the register
// defaults (id 255, offset 12). When the result receiver stalls, only the
// final byte of the next message waits; the queue then holds it and one more
// beat, after which msg.ready falls.
module dns_reply_address_extractor (
    input  logic         clk,
    input  logic         rst_n,
    dre_byte_if.sink     msg,
    dre_cfg_if.sink      cfg,
    dre_result_if.source result
);
    import dre_pkg::*;

    logic [IdW-1:0]   query_id_reg;
    logic [QendW-1:0] qend_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    beat_t            q_in;
    beat_t            q_head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_id_reg <= QueryIdReset;
            qend_reg     <= QendMin;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_QUERY_ID:     query_id_reg <= cfg.data;
                CFG_QUESTION_END: qend_reg     <= cfg.data[QendW-1:0];
                default: ;
            endcase
        end
    end

    dre_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg          (msg),
        .question_end (qend_reg),
        .queue_full   (q_full),
        .push         (q_push),
        .beat         (q_in)
    );

    dre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_beat (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    dre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .query_id   (query_id_reg),
        .beat_valid (q_not_empty),
        .beat       (q_head),
        .pop        (q_pop),
        .result     (result)
    );

    // The status code stays within the defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status <= ST_TRUNCATED))
        else $error("result status out of range");

    // An address is reported only together with a found status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != ST_FOUND)) |-> (result.address == '0))
        else $error("address reported without a found status");

    // Taking the final byte of a message from the queue produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.last_byte) |=> result.valid)
        else $error("message end did not produce a result");

    // The queue never pops when it is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("pop from an empty queue");

endmodule
